FILE: rtl/dbpdet_pkg.sv
// dbpdet_pkg: widths, register indexes, reset values, shared types and the
// popcount helper for the DBPSK preamble detector.
// No dependencies.
`timescale 1ns / 1ps

package dbpdet_pkg;

	localparam int CHANNELS    = 1024;
	localparam int IDX_W       = $clog2(CHANNELS);
	localparam int CHAN_W      = 10;
	localparam int SAMPLE_BITS = 16;
	localparam int SAMP_PAIR_W = 2 * SAMPLE_BITS;
	localparam int PROD_W      = 2 * SAMPLE_BITS;
	localparam int SUM_W       = PROD_W + 1;
	localparam int SHIFT_W     = 32;
	localparam int MSB_POS     = SHIFT_W - 1;
	localparam int BITS_W      = 2 * SHIFT_W;
	localparam int ERR_W       = 6;
	localparam int OUT_DATA_W  = 16;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR = CFG_IDX_W'(1);

	localparam logic [SHIFT_W-1:0] PATTERN_RESET = 32'h97157A6F;
	localparam logic [ERR_W-1:0]   MAX_ERR_RESET = ERR_W'(3);

	typedef struct packed {
		logic dot_pos;
		logic cross_pos;
	} diff_t;

	typedef struct packed {
		logic [ERR_W-1:0] err_quad;
		logic [ERR_W-1:0] err_direct;
		logic             match_both_inverted;
		logic             match_bits_inverted;
		logic             match_iq_rotated;
		logic             match_normal;
	} score_t;

	// channel number to state entry, wraps at CHANNELS (power of two)
	function automatic logic [IDX_W-1:0] chan_to_idx(input logic [CHAN_W-1:0] chan);
		return IDX_W'(32'(chan) % CHANNELS);
	endfunction

	// nibble counts, then an 8-term sum
	function automatic logic [ERR_W-1:0] popcount(input logic [SHIFT_W-1:0] v);
		logic [2:0]       nib [SHIFT_W/4];
		logic [ERR_W-1:0] sum;
		for (int k = 0; k < SHIFT_W/4; k++) begin
			nib[k] = 3'(v[4*k]) + 3'(v[4*k+1]) + 3'(v[4*k+2]) + 3'(v[4*k+3]);
		end
		sum = '0;
		for (int k = 0; k < SHIFT_W/4; k++) begin
			sum = sum + ERR_W'(nib[k]);
		end
		return sum;
	endfunction

endpackage

FILE: rtl/dbpsk_preamble_detector.sv
// dbpsk_preamble_detector: per-channel DBPSK differential preamble correlator.
// Uses dbpdet_pkg, dbpdet_ram, dbpdet_diff, dbpdet_score.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                Payload
// s_*       in   s_tvalid / s_tready      tuser: channel; tdata: sample_i, sample_q
// m_*       out  m_tvalid / m_tready      tuser: result_channel; tdata: flags, errors
// cfg_*     in   cfg_valid / cfg_ready    cfg_index, cfg_data (0 pattern, 1 error threshold)
//
// One transaction per clock sustained, except during an m_tready stall or the clearing pass.
// Stages: s1 multiply, s2 sign/shift + state write, s3 popcount, output register.
// State sits in two RAMs: previous samples (written on accept) and the two shift
// registers (written in s2, forwarded to the two following items of a channel).
// After reset a clearing pass zeroes all CHANNELS entries with s_tready low; cfg writes
// are taken throughout. A stall on m_tready freezes every stage and the RAM ports together.

module dbpsk_preamble_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dbpdet_pkg::SAMP_PAIR_W-1:0]  s_tdata,   // sample_i, sample_q
	input  logic [dbpdet_pkg::CHAN_W-1:0]       s_tuser,   // channel
	// master stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// match_normal, match_iq_rotated, match_bits_inverted, match_both_inverted,
	// errors_direct, errors_quadrature
	output logic [dbpdet_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [dbpdet_pkg::CHAN_W-1:0]       m_tuser,   // result_channel
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dbpdet_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dbpdet_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dbpdet_pkg::*;

	// config registers
	logic [SHIFT_W-1:0] pattern_q;
	logic [ERR_W-1:0]   max_err_q;

	// clearing pass
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_cnt_q;

	// handshake
	logic             accept, adv;
	logic [IDX_W-1:0] cur_idx;

	// RAM ports
	logic                   samp_we;
	logic [IDX_W-1:0]       samp_waddr;
	logic [SAMP_PAIR_W-1:0] samp_wdata, samp_rdata;
	logic                   bits_we;
	logic [IDX_W-1:0]       bits_waddr;
	logic [BITS_W-1:0]      bits_wdata, bits_rdata;

	// s1
	logic                          valid_s1;
	logic [CHAN_W-1:0]             chan_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic signed [SAMPLE_BITS-1:0] si_s1, sq_s1;

	// s2
	logic              valid_s2;
	logic [CHAN_W-1:0] chan_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [BITS_W-1:0] bits_s2;
	diff_t             diff;
	logic [BITS_W-1:0] old_bits, new_bits;

	// last two shift-register writes, for forwarding
	logic              wr1_valid_q, wr2_valid_q;
	logic [IDX_W-1:0]  wr1_idx_q, wr2_idx_q;
	logic [BITS_W-1:0] wr1_data_q, wr2_data_q;

	// s3
	logic               valid_s3;
	logic [CHAN_W-1:0]  chan_s3;
	logic [SHIFT_W-1:0] phase_s3, quad_s3;
	score_t             score;

	// output register
	logic              out_valid_q;
	logic [CHAN_W-1:0] out_chan_q;
	score_t            out_score_q;

	assign adv       = !out_valid_q || m_tready;
	assign s_tready  = adv && !clr_busy_q;
	assign accept    = s_tvalid && s_tready;
	assign cur_idx   = chan_to_idx(s_tuser);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PATTERN_RESET;
			max_err_q <= MAX_ERR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PATTERN: pattern_q <= cfg_data[SHIFT_W-1:0];
				REG_MAX_ERR: max_err_q <= cfg_data[ERR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == IDX_W'(CHANNELS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
		end
	end

	// previous-sample store: read and overwrite at the same edge (old data returned)
	assign samp_we    = accept || clr_busy_q;
	assign samp_waddr = clr_busy_q ? clr_cnt_q : cur_idx;
	assign samp_wdata = clr_busy_q ? '0 : s_tdata;

	dbpdet_ram #(
		.WIDTH(SAMP_PAIR_W),
		.DEPTH(CHANNELS)
	) u_samp_ram (
		.clk  (clk),
		.we   (samp_we),
		.waddr(samp_waddr),
		.wdata(samp_wdata),
		.re   (accept),
		.raddr(cur_idx),
		.rdata(samp_rdata)
	);

	// shift-register store, {quad, phase}
	assign bits_we    = clr_busy_q || (adv && valid_s2);
	assign bits_waddr = clr_busy_q ? clr_cnt_q : idx_s2;
	assign bits_wdata = clr_busy_q ? '0 : new_bits;

	dbpdet_ram #(
		.WIDTH(BITS_W),
		.DEPTH(CHANNELS)
	) u_bits_ram (
		.clk  (clk),
		.we   (bits_we),
		.waddr(bits_waddr),
		.wdata(bits_wdata),
		.re   (accept),
		.raddr(cur_idx),
		.rdata(bits_rdata)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			wr1_valid_q <= 1'b0;
			wr2_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			wr1_valid_q <= valid_s2;
			wr2_valid_q <= wr1_valid_q;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			chan_s1     <= s_tuser;
			idx_s1      <= cur_idx;
			si_s1       <= s_tdata[SAMPLE_BITS-1:0];
			sq_s1       <= s_tdata[SAMP_PAIR_W-1:SAMPLE_BITS];
			chan_s2     <= chan_s1;
			idx_s2      <= idx_s1;
			bits_s2     <= bits_rdata;
			wr1_idx_q   <= idx_s2;
			wr1_data_q  <= new_bits;
			wr2_idx_q   <= wr1_idx_q;
			wr2_data_q  <= wr1_data_q;
			chan_s3     <= chan_s2;
			phase_s3    <= new_bits[SHIFT_W-1:0];
			quad_s3     <= new_bits[BITS_W-1:SHIFT_W];
			out_chan_q  <= chan_s3;
			out_score_q <= score;
		end
	end

	dbpdet_diff u_diff (
		.clk    (clk),
		.en     (adv),
		.prev_si($signed(samp_rdata[SAMPLE_BITS-1:0])),
		.prev_sq($signed(samp_rdata[SAMP_PAIR_W-1:SAMPLE_BITS])),
		.cur_si (si_s1),
		.cur_sq (sq_s1),
		.diff   (diff)
	);

	// s2: the RAM read may predate the last two writes of the same channel
	always_comb begin
		if (wr1_valid_q && (wr1_idx_q == idx_s2)) begin
			old_bits = wr1_data_q;
		end else if (wr2_valid_q && (wr2_idx_q == idx_s2)) begin
			old_bits = wr2_data_q;
		end else begin
			old_bits = bits_s2;
		end
		new_bits[SHIFT_W-1:0]      = {diff.dot_pos, old_bits[MSB_POS:1]};
		new_bits[BITS_W-1:SHIFT_W] = {diff.cross_pos, old_bits[BITS_W-1:SHIFT_W+1]};
	end

	dbpdet_score u_score (
		.pattern   (pattern_q),
		.max_err   (max_err_q),
		.phase_bits(phase_s3),
		.quad_bits (quad_s3),
		.score     (score)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_chan_q;
	assign m_tdata  = {out_score_q.err_quad, out_score_q.err_direct,
		out_score_q.match_both_inverted, out_score_q.match_bits_inverted,
		out_score_q.match_iq_rotated, out_score_q.match_normal};

endmodule

FILE: rtl/dbpdet_ram.sv
// dbpdet_ram: generic simple dual-port RAM, one write and one registered read.
// Read-during-write to the same address returns the old contents.
`timescale 1ns / 1ps

module dbpdet_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/dbpdet_diff.sv
// dbpdet_diff: differential products of previous and current sample, one
// register stage after the multipliers, then sign tests. Uses dbpdet_pkg.
`timescale 1ns / 1ps

module dbpdet_diff (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [dbpdet_pkg::SAMPLE_BITS-1:0] prev_si,
	input  logic signed [dbpdet_pkg::SAMPLE_BITS-1:0] prev_sq,
	input  logic signed [dbpdet_pkg::SAMPLE_BITS-1:0] cur_si,
	input  logic signed [dbpdet_pkg::SAMPLE_BITS-1:0] cur_sq,
	output dbpdet_pkg::diff_t                   diff
);
	import dbpdet_pkg::*;

	// internal I is the imaginary part, internal Q the real part
	logic signed [PROD_W-1:0] p_ii_s2, p_qq_s2, p_iq_s2, p_qi_s2;
	logic signed [SUM_W-1:0]  dot, cross_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			p_ii_s2 <= prev_si * cur_si;
			p_qq_s2 <= prev_sq * cur_sq;
			p_iq_s2 <= prev_si * cur_sq;
			p_qi_s2 <= prev_sq * cur_si;
		end
	end

	always_comb begin
		dot            = SUM_W'(p_ii_s2) + SUM_W'(p_qq_s2);
		cross_sum      = SUM_W'(p_iq_s2) - SUM_W'(p_qi_s2);
		diff.dot_pos   = !dot[SUM_W-1] && (dot != '0);
		diff.cross_pos = !cross_sum[SUM_W-1] && (cross_sum != '0);
	end

endmodule

FILE: rtl/dbpdet_score.sv
// dbpdet_score: Hamming distances of the two shift registers against the preamble word
// (inverted for the quad register) and the four threshold flags. Uses dbpdet_pkg.
`timescale 1ns / 1ps

module dbpdet_score (
	input  logic [dbpdet_pkg::SHIFT_W-1:0] pattern,
	input  logic [dbpdet_pkg::ERR_W-1:0]   max_err,
	input  logic [dbpdet_pkg::SHIFT_W-1:0] phase_bits,
	input  logic [dbpdet_pkg::SHIFT_W-1:0] quad_bits,
	output dbpdet_pkg::score_t             score
);
	import dbpdet_pkg::*;

	logic [ERR_W-1:0] err_d, err_q;

	always_comb begin
		err_d                     = popcount(phase_bits ^ pattern);
		err_q                     = popcount(quad_bits ^ ~pattern);
		score.err_direct          = err_d;
		score.err_quad            = err_q;
		score.match_normal        = err_d <= max_err;
		score.match_iq_rotated    = err_q <= max_err;
		score.match_bits_inverted = (ERR_W'(SHIFT_W) - err_d) <= max_err;
		score.match_both_inverted = (ERR_W'(SHIFT_W) - err_q) <= max_err;
	end

endmodule
